/* rtl/aesenc_pkg.sv */
// ----------------------------------------------------------------------------
// AES-128 encrypt package
// Shared widths, command codes and the byte-level round functions.
// ----------------------------------------------------------------------------
package aesenc_pkg;

    localparam int BLOCK_W    = 128;
    localparam int HALF_W     = 64;
    localparam int KEY_IDX_W  = 4;
    localparam int ROUNDS_DEF = 10;

    typedef enum logic [0:0] {
        CMD_LOAD_KEY = 1'b0,
        CMD_ENCRYPT  = 1'b1
    } t_cmd;

    typedef logic [BLOCK_W-1:0] t_block;

    // forward S-box
    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] s;
        case (a)
            8'h00: s=8'h63; 8'h01: s=8'h7c; 8'h02: s=8'h77; 8'h03: s=8'h7b;
            8'h04: s=8'hf2; 8'h05: s=8'h6b; 8'h06: s=8'h6f; 8'h07: s=8'hc5;
            8'h08: s=8'h30; 8'h09: s=8'h01; 8'h0a: s=8'h67; 8'h0b: s=8'h2b;
            8'h0c: s=8'hfe; 8'h0d: s=8'hd7; 8'h0e: s=8'hab; 8'h0f: s=8'h76;
            8'h10: s=8'hca; 8'h11: s=8'h82; 8'h12: s=8'hc9; 8'h13: s=8'h7d;
            8'h14: s=8'hfa; 8'h15: s=8'h59; 8'h16: s=8'h47; 8'h17: s=8'hf0;
            8'h18: s=8'had; 8'h19: s=8'hd4; 8'h1a: s=8'ha2; 8'h1b: s=8'haf;
            8'h1c: s=8'h9c; 8'h1d: s=8'ha4; 8'h1e: s=8'h72; 8'h1f: s=8'hc0;
            8'h20: s=8'hb7; 8'h21: s=8'hfd; 8'h22: s=8'h93; 8'h23: s=8'h26;
            8'h24: s=8'h36; 8'h25: s=8'h3f; 8'h26: s=8'hf7; 8'h27: s=8'hcc;
            8'h28: s=8'h34; 8'h29: s=8'ha5; 8'h2a: s=8'he5; 8'h2b: s=8'hf1;
            8'h2c: s=8'h71; 8'h2d: s=8'hd8; 8'h2e: s=8'h31; 8'h2f: s=8'h15;
            8'h30: s=8'h04; 8'h31: s=8'hc7; 8'h32: s=8'h23; 8'h33: s=8'hc3;
            8'h34: s=8'h18; 8'h35: s=8'h96; 8'h36: s=8'h05; 8'h37: s=8'h9a;
            8'h38: s=8'h07; 8'h39: s=8'h12; 8'h3a: s=8'h80; 8'h3b: s=8'he2;
            8'h3c: s=8'heb; 8'h3d: s=8'h27; 8'h3e: s=8'hb2; 8'h3f: s=8'h75;
            8'h40: s=8'h09; 8'h41: s=8'h83; 8'h42: s=8'h2c; 8'h43: s=8'h1a;
            8'h44: s=8'h1b; 8'h45: s=8'h6e; 8'h46: s=8'h5a; 8'h47: s=8'ha0;
            8'h48: s=8'h52; 8'h49: s=8'h3b; 8'h4a: s=8'hd6; 8'h4b: s=8'hb3;
            8'h4c: s=8'h29; 8'h4d: s=8'he3; 8'h4e: s=8'h2f; 8'h4f: s=8'h84;
            8'h50: s=8'h53; 8'h51: s=8'hd1; 8'h52: s=8'h00; 8'h53: s=8'hed;
            8'h54: s=8'h20; 8'h55: s=8'hfc; 8'h56: s=8'hb1; 8'h57: s=8'h5b;
            8'h58: s=8'h6a; 8'h59: s=8'hcb; 8'h5a: s=8'hbe; 8'h5b: s=8'h39;
            8'h5c: s=8'h4a; 8'h5d: s=8'h4c; 8'h5e: s=8'h58; 8'h5f: s=8'hcf;
            8'h60: s=8'hd0; 8'h61: s=8'hef; 8'h62: s=8'haa; 8'h63: s=8'hfb;
            8'h64: s=8'h43; 8'h65: s=8'h4d; 8'h66: s=8'h33; 8'h67: s=8'h85;
            8'h68: s=8'h45; 8'h69: s=8'hf9; 8'h6a: s=8'h02; 8'h6b: s=8'h7f;
            8'h6c: s=8'h50; 8'h6d: s=8'h3c; 8'h6e: s=8'h9f; 8'h6f: s=8'ha8;
            8'h70: s=8'h51; 8'h71: s=8'ha3; 8'h72: s=8'h40; 8'h73: s=8'h8f;
            8'h74: s=8'h92; 8'h75: s=8'h9d; 8'h76: s=8'h38; 8'h77: s=8'hf5;
            8'h78: s=8'hbc; 8'h79: s=8'hb6; 8'h7a: s=8'hda; 8'h7b: s=8'h21;
            8'h7c: s=8'h10; 8'h7d: s=8'hff; 8'h7e: s=8'hf3; 8'h7f: s=8'hd2;
            8'h80: s=8'hcd; 8'h81: s=8'h0c; 8'h82: s=8'h13; 8'h83: s=8'hec;
            8'h84: s=8'h5f; 8'h85: s=8'h97; 8'h86: s=8'h44; 8'h87: s=8'h17;
            8'h88: s=8'hc4; 8'h89: s=8'ha7; 8'h8a: s=8'h7e; 8'h8b: s=8'h3d;
            8'h8c: s=8'h64; 8'h8d: s=8'h5d; 8'h8e: s=8'h19; 8'h8f: s=8'h73;
            8'h90: s=8'h60; 8'h91: s=8'h81; 8'h92: s=8'h4f; 8'h93: s=8'hdc;
            8'h94: s=8'h22; 8'h95: s=8'h2a; 8'h96: s=8'h90; 8'h97: s=8'h88;
            8'h98: s=8'h46; 8'h99: s=8'hee; 8'h9a: s=8'hb8; 8'h9b: s=8'h14;
            8'h9c: s=8'hde; 8'h9d: s=8'h5e; 8'h9e: s=8'h0b; 8'h9f: s=8'hdb;
            8'ha0: s=8'he0; 8'ha1: s=8'h32; 8'ha2: s=8'h3a; 8'ha3: s=8'h0a;
            8'ha4: s=8'h49; 8'ha5: s=8'h06; 8'ha6: s=8'h24; 8'ha7: s=8'h5c;
            8'ha8: s=8'hc2; 8'ha9: s=8'hd3; 8'haa: s=8'hac; 8'hab: s=8'h62;
            8'hac: s=8'h91; 8'had: s=8'h95; 8'hae: s=8'he4; 8'haf: s=8'h79;
            8'hb0: s=8'he7; 8'hb1: s=8'hc8; 8'hb2: s=8'h37; 8'hb3: s=8'h6d;
            8'hb4: s=8'h8d; 8'hb5: s=8'hd5; 8'hb6: s=8'h4e; 8'hb7: s=8'ha9;
            8'hb8: s=8'h6c; 8'hb9: s=8'h56; 8'hba: s=8'hf4; 8'hbb: s=8'hea;
            8'hbc: s=8'h65; 8'hbd: s=8'h7a; 8'hbe: s=8'hae; 8'hbf: s=8'h08;
            8'hc0: s=8'hba; 8'hc1: s=8'h78; 8'hc2: s=8'h25; 8'hc3: s=8'h2e;
            8'hc4: s=8'h1c; 8'hc5: s=8'ha6; 8'hc6: s=8'hb4; 8'hc7: s=8'hc6;
            8'hc8: s=8'he8; 8'hc9: s=8'hdd; 8'hca: s=8'h74; 8'hcb: s=8'h1f;
            8'hcc: s=8'h4b; 8'hcd: s=8'hbd; 8'hce: s=8'h8b; 8'hcf: s=8'h8a;
            8'hd0: s=8'h70; 8'hd1: s=8'h3e; 8'hd2: s=8'hb5; 8'hd3: s=8'h66;
            8'hd4: s=8'h48; 8'hd5: s=8'h03; 8'hd6: s=8'hf6; 8'hd7: s=8'h0e;
            8'hd8: s=8'h61; 8'hd9: s=8'h35; 8'hda: s=8'h57; 8'hdb: s=8'hb9;
            8'hdc: s=8'h86; 8'hdd: s=8'hc1; 8'hde: s=8'h1d; 8'hdf: s=8'h9e;
            8'he0: s=8'he1; 8'he1: s=8'hf8; 8'he2: s=8'h98; 8'he3: s=8'h11;
            8'he4: s=8'h69; 8'he5: s=8'hd9; 8'he6: s=8'h8e; 8'he7: s=8'h94;
            8'he8: s=8'h9b; 8'he9: s=8'h1e; 8'hea: s=8'h87; 8'heb: s=8'he9;
            8'hec: s=8'hce; 8'hed: s=8'h55; 8'hee: s=8'h28; 8'hef: s=8'hdf;
            8'hf0: s=8'h8c; 8'hf1: s=8'ha1; 8'hf2: s=8'h89; 8'hf3: s=8'h0d;
            8'hf4: s=8'hbf; 8'hf5: s=8'he6; 8'hf6: s=8'h42; 8'hf7: s=8'h68;
            8'hf8: s=8'h41; 8'hf9: s=8'h99; 8'hfa: s=8'h2d; 8'hfb: s=8'h0f;
            8'hfc: s=8'hb0; 8'hfd: s=8'h54; 8'hfe: s=8'hbb; 8'hff: s=8'h16;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a block, byte 0 in the top bits
    function automatic logic [7:0] byte_of(input t_block b, input int i);
        return b[BLOCK_W-1-8*i -: 8];
    endfunction

endpackage

/* rtl/aesenc_round_cell.sv */
// ----------------------------------------------------------------------------
// AES round cell
// One full round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
// Registers its state and valid and hands both to the next cell.
// ----------------------------------------------------------------------------
module aesenc_round_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_mix,
    input  logic                  i_vld,
    input  aesenc_pkg::t_block    i_state,
    input  aesenc_pkg::t_block    i_key,
    output logic                  o_vld,
    output aesenc_pkg::t_block    o_state
);
    import aesenc_pkg::*;

    logic [7:0] w_ss [16];
    logic [7:0] w_mx [16];
    t_block     n_state;
    logic       r_vld;
    t_block     r_state;

    // substitute and shift rows
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                w_ss[r + 4*c] = sbox(byte_of(i_state, r + 4*((c + r) % 4)));
            end
        end
    end

    // mix columns
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            w_mx[4*c]   = xt(w_ss[4*c]) ^ xt(w_ss[4*c+1]) ^ w_ss[4*c+1]
                        ^ w_ss[4*c+2] ^ w_ss[4*c+3];
            w_mx[4*c+1] = w_ss[4*c] ^ xt(w_ss[4*c+1]) ^ xt(w_ss[4*c+2])
                        ^ w_ss[4*c+2] ^ w_ss[4*c+3];
            w_mx[4*c+2] = w_ss[4*c] ^ w_ss[4*c+1] ^ xt(w_ss[4*c+2])
                        ^ xt(w_ss[4*c+3]) ^ w_ss[4*c+3];
            w_mx[4*c+3] = xt(w_ss[4*c]) ^ w_ss[4*c] ^ w_ss[4*c+1]
                        ^ w_ss[4*c+2] ^ xt(w_ss[4*c+3]);
        end
    end

    // add round key
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            n_state[BLOCK_W-1-8*i -: 8] = (i_mix ? w_mx[i] : w_ss[i])
                                        ^ byte_of(i_key, i);
        end
    end

    // advance one cell when the chain moves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_state <= n_state;
        end
    end

    assign o_vld   = r_vld;
    assign o_state = r_state;

endmodule

/* rtl/aes128_block_encrypt_unit.sv */
// ----------------------------------------------------------------------------
// AES-128 block encrypt unit
// Round-key store plus a chain of round cells, one per round.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | i_valid / o_stall   | i_cmd i_key_index i_data_hi/lo
//  out     | output    | o_valid / i_stall   | o_cipher_hi o_cipher_lo
//
// An encrypt beat passes the key-add stage and ROUNDS round cells in order;
// one encrypt beat may enter every cycle while nothing stalls. The whole chain
// advances together, so an output stall holds every cell and stalls the input.
// A key load beat waits until the chain is empty, so blocks in flight keep
// the schedule they entered with.
// Reset clears valid bits only; round keys are undefined until loaded.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_unit #(
    parameter int ROUNDS = aesenc_pkg::ROUNDS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_cmd,
    input  logic [aesenc_pkg::KEY_IDX_W-1:0]  i_key_index,
    input  logic [aesenc_pkg::HALF_W-1:0]     i_data_hi,
    input  logic [aesenc_pkg::HALF_W-1:0]     i_data_lo,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [aesenc_pkg::HALF_W-1:0]     o_cipher_hi,
    output logic [aesenc_pkg::HALF_W-1:0]     o_cipher_lo
);
    import aesenc_pkg::*;

    localparam int NKEYS = ROUNDS + 1;

    t_block r_keys [NKEYS];
    logic   w_vld  [ROUNDS+1];
    t_block w_st   [ROUNDS+1];
    logic   r_vld0;
    t_block r_st0;
    logic   w_adv;
    logic   w_acc;
    logic   w_busy;
    logic   w_load_wait;
    t_block w_in;

    // any block still in the chain
    always_comb begin
        w_busy = 1'b0;
        for (int g = 0; g <= ROUNDS; g++) begin
            w_busy = w_busy | w_vld[g];
        end
    end

    assign w_in        = {i_data_hi, i_data_lo};
    assign w_adv       = !(w_vld[ROUNDS] && i_stall);
    assign w_load_wait = i_valid && i_cmd == CMD_LOAD_KEY && w_busy;
    assign o_stall     = !w_adv || w_load_wait;
    assign w_acc       = i_valid && !o_stall;

    // load a round key; drop out-of-range indexes
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NKEYS; k++) begin
            if (w_acc && i_cmd == CMD_LOAD_KEY
                && i_key_index == KEY_IDX_W'(k)) begin
                r_keys[k] <= w_in;
            end
        end
    end

    // initial key addition stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else if (w_adv) begin
            r_vld0 <= w_acc && i_cmd == CMD_ENCRYPT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_st0 <= w_in ^ r_keys[0];
        end
    end

    assign w_vld[0] = r_vld0;
    assign w_st[0]  = r_st0;

    for (genvar g = 1; g <= ROUNDS; g++) begin : g_round
        aesenc_round_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_mix   (g != ROUNDS),
            .i_vld   (w_vld[g-1]),
            .i_state (w_st[g-1]),
            .i_key   (r_keys[g]),
            .o_vld   (w_vld[g]),
            .o_state (w_st[g])
        );
    end

    assign o_valid     = w_vld[ROUNDS];
    assign o_cipher_hi = w_st[ROUNDS][BLOCK_W-1:HALF_W];
    assign o_cipher_lo = w_st[ROUNDS][HALF_W-1:0];

`ifndef SYNTHESIS
    // a stalled result holds in the chain
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_cipher_hi))
        else $error("result lost under stall");
    // input stalls only while the output is stalled or a load waits
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall) || w_load_wait)
        else $error("spurious input stall");
    // a load beat never enters the chain
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && i_cmd == CMD_LOAD_KEY |=> !r_vld0)
        else $error("load beat in datapath");
    // a key changes only while the chain is empty
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && i_cmd == CMD_LOAD_KEY |-> !w_busy)
        else $error("key load with blocks in flight");
`endif

endmodule

/* dv/aes128_block_encrypt_unit_tb.sv */
// ----------------------------------------------------------------------------
// AES-128 block encrypt unit testbench
// Loads round-key schedules, encrypts directed and random blocks, predicts
// each ciphertext in the bench and checks every output beat in order.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_unit_tb;
    import aesenc_pkg::*;

    localparam int NKEYS     = ROUNDS_DEF + 1;
    localparam int LAT       = ROUNDS_DEF + 1;
    localparam int LIMIT_CYC = 400000;
    localparam int N_ITEMS   = 1750;

    typedef struct {
        t_cmd        cmd;
        logic [3:0]  idx;
        logic [63:0] hi;
        logic [63:0] lo;
    } t_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_cmd;
    logic [3:0]  i_key_index;
    logic [63:0] i_data_hi;
    logic [63:0] i_data_lo;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_cipher_hi;
    logic [63:0] o_cipher_lo;

    t_beat       pending_beats[$];
    logic [127:0] cipher_fifo[$];
    logic [127:0] key_sched[NKEYS];
    logic [7:0]  sbox_tab[256];
    int          mismatches;
    int          cycles;
    bit          quiet;

    aes128_block_encrypt_unit u_top (.*);

    // Generate clock
    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    function automatic logic [7:0] gmul2(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Predict ciphertext from the bench copy of the key schedule
    function automatic logic [127:0] encrypt_block(input logic [127:0] pt);
        logic [7:0] st[16];
        logic [7:0] tmp[16];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] res;
        for (int i = 0; i < 16; i++) st[i] = pt[127-8*i -: 8];
        for (int k = 0; k <= ROUNDS_DEF; k++) begin
            if (k > 0) begin
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        tmp[r+4*c] = sbox_tab[st[r+4*((c+r)%4)]];
                st = tmp;
                if (k < ROUNDS_DEF) begin
                    for (int c = 0; c < 4; c++) begin
                        a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
                        st[4*c]   = gmul2(a0) ^ gmul2(a1) ^ a1 ^ a2 ^ a3;
                        st[4*c+1] = a0 ^ gmul2(a1) ^ gmul2(a2) ^ a2 ^ a3;
                        st[4*c+2] = a0 ^ a1 ^ gmul2(a2) ^ gmul2(a3) ^ a3;
                        st[4*c+3] = gmul2(a0) ^ a0 ^ a1 ^ a2 ^ gmul2(a3);
                    end
                end
            end
            for (int i = 0; i < 16; i++) st[i] ^= key_sched[k][127-8*i -: 8];
        end
        for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic add_beat(input t_cmd c, input logic [3:0] k,
                            input logic [63:0] h, input logic [63:0] l);
        t_beat b;
        b.cmd = c; b.idx = k; b.hi = h; b.lo = l;
        pending_beats.push_back(b);
    endtask

    task automatic add_schedule();
        for (int k = 0; k < NKEYS; k++)
            add_beat(CMD_LOAD_KEY, 4'(k), rand64(), rand64());
    endtask

    // Drive input beats at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && o_stall)) begin
            if (pending_beats.size() > 0 && (quiet || $urandom_range(99) >= 12)) begin
                i_valid     <= 1'b1;
                i_cmd       <= pending_beats[0].cmd;
                i_key_index <= pending_beats[0].idx;
                i_data_hi   <= pending_beats[0].hi;
                i_data_lo   <= pending_beats[0].lo;
                void'(pending_beats.pop_front());
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_stall <= i_rst_n && !quiet && ($urandom_range(99) < 12);
    end

    // Predict on accepted input beats, check output beats
    always @(posedge i_clk) begin
        logic [127:0] exp_c;
        cycles <= cycles + 1;
        if (i_rst_n && i_valid && !o_stall) begin
            if (t_cmd'(i_cmd) == CMD_LOAD_KEY) begin
                if (i_key_index < NKEYS) key_sched[i_key_index] = {i_data_hi, i_data_lo};
            end else begin
                cipher_fifo.push_back(encrypt_block({i_data_hi, i_data_lo}));
            end
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (cipher_fifo.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat %h %h", o_cipher_hi, o_cipher_lo);
            end else begin
                exp_c = cipher_fifo.pop_front();
                if (o_cipher_hi !== exp_c[127:64] || o_cipher_lo !== exp_c[63:0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %h %h got %h %h",
                                 exp_c[127:64], exp_c[63:0], o_cipher_hi, o_cipher_lo);
                end
            end
        end
        if (cycles > LIMIT_CYC) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        logic [7:0] p, q, x;
        // Build S-box from the field inverse and the affine map
        p = 8'h01; q = 8'h01;
        do begin
            p = p ^ gmul2(p);
            q = q ^ {q[6:0], 1'b0};
            q = q ^ {q[5:0], 2'b0};
            q = q ^ {q[3:0], 4'b0};
            if (q[7]) q = q ^ 8'h09;
            x = q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]}
                  ^ {q[3:0], q[7:4]};
            sbox_tab[p] = x ^ 8'h63;
        end while (p != 8'h01);
        sbox_tab[0] = 8'h63;

        mismatches = 0; cycles = 0; quiet = 1'b0;
        i_rst_n = 1'b0; i_valid = 1'b0; i_stall = 1'b0; i_cmd = 1'b0;
        i_key_index = '0; i_data_hi = '0; i_data_lo = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: known FIPS-197 vector, then extreme keys and data
        add_beat(CMD_LOAD_KEY, 4'd0,  64'h0001020304050607, 64'h08090a0b0c0d0e0f);
        add_beat(CMD_LOAD_KEY, 4'd1,  64'hd6aa74fdd2af72fa, 64'hdaa678f1d6ab76fe);
        add_beat(CMD_LOAD_KEY, 4'd2,  64'hb692cf0b643dbdf1, 64'hbe9bc5006830b3fe);
        add_beat(CMD_LOAD_KEY, 4'd3,  64'hb6ff744ed2c2c9bf, 64'h6c590cbf0469bf41);
        add_beat(CMD_LOAD_KEY, 4'd4,  64'h47f7f7bc95353e03, 64'hf96c32bcfd058dfd);
        add_beat(CMD_LOAD_KEY, 4'd5,  64'h3caaa3e8a99f9deb, 64'h50f3af57adf622aa);
        add_beat(CMD_LOAD_KEY, 4'd6,  64'h5e390f7df7a69296, 64'ha7553dc10aa31f6b);
        add_beat(CMD_LOAD_KEY, 4'd7,  64'h14f9701ae35fe28c, 64'h440adf4d4ea9c026);
        add_beat(CMD_LOAD_KEY, 4'd8,  64'h47438735a41c65b9, 64'he016baf4aebf7ad2);
        add_beat(CMD_LOAD_KEY, 4'd9,  64'h549932d1f0855768, 64'h1093ed9cbe2c974e);
        add_beat(CMD_LOAD_KEY, 4'd10, 64'h13111d7fe3944a17, 64'hf307a78b4d2b30c5);
        add_beat(CMD_ENCRYPT, 4'd0,  64'h0011223344556677, 64'h8899aabbccddeeff);
        add_beat(CMD_ENCRYPT, 4'd15, 64'h0, 64'h0);
        add_beat(CMD_ENCRYPT, 4'd5,  '1, '1);
        // Out-of-range index: ignored, must not disturb the schedule
        add_beat(CMD_LOAD_KEY, 4'd11, '1, '1);
        add_beat(CMD_LOAD_KEY, 4'd15, 64'h0, 64'h0);
        add_beat(CMD_ENCRYPT, 4'd0,  64'h0011223344556677, 64'h8899aabbccddeeff);
        add_beat(CMD_LOAD_KEY, 4'd10, '1, '1);
        add_beat(CMD_LOAD_KEY, 4'd0,  64'h0, 64'h0);
        add_beat(CMD_ENCRYPT, 4'd0,  64'h8000000000000000, 64'h1);

        // Random: mostly encrypts under a live schedule, occasional rekeys
        while (pending_beats.size() < N_ITEMS) begin
            if ($urandom_range(99) < 3) add_schedule();
            else if ($urandom_range(99) < 8)
                add_beat(CMD_LOAD_KEY, 4'($urandom_range(15)), rand64(), rand64());
            else
                add_beat(CMD_ENCRYPT, 4'($urandom_range(15)), rand64(), rand64());
        end

        // Let a stretch run with no idling on either side
        wait (pending_beats.size() < 600);
        quiet = 1'b1;
        wait (pending_beats.size() < 300);
        quiet = 1'b0;

        wait (pending_beats.size() == 0 && cipher_fifo.size() == 0);
        repeat (4 * LAT) @(posedge i_clk);
        if (mismatches == 0 && cipher_fifo.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
